### hdl/assert_macros.svh
// Assertion helpers shared by the RTL. Each macro expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SPD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`define SPD_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed");
`else
`define SPD_ASSERT(label, prop)
`define SPD_ASSERT_NEXT(label, cond, expr)
`endif

`endif

### hdl/spd_pkg.sv
package spd_pkg;

  localparam int FRAME_LEN = 20;
  localparam int HOLD_LEN  = FRAME_LEN - 1;
  localparam int FILL_W    = $clog2(FRAME_LEN);

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [7:0] HDR_LEN_BYTE  = 8'd19;
  localparam logic [7:0] HDR_SYNC_BYTE = 8'd17;
  localparam logic [7:0] ID_LEFT       = 8'd28;
  localparam logic [7:0] ID_FRONT_LEFT = 8'd29;
  localparam logic [7:0] ID_FRONT_RGT  = 8'd30;
  localparam logic [7:0] ID_RIGHT      = 8'd31;
  localparam logic [7:0] ID_TRAVEL     = 8'd19;
  localparam logic [7:0] ID_INFRARED   = 8'd17;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_THR_LEFT        = 3'd0,
    CFG_THR_FRONT_LEFT  = 3'd1,
    CFG_THR_FRONT_RIGHT = 3'd2,
    CFG_THR_RIGHT       = 3'd3,
    CFG_POLARITY        = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [15:0] threshold_left;
    logic [15:0] threshold_front_left;
    logic [15:0] threshold_front_right;
    logic [15:0] threshold_right;
    logic        flag_polarity;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        left_raw;
    logic [15:0]        front_left_raw;
    logic [15:0]        front_right_raw;
    logic [15:0]        right_raw;
    logic signed [15:0] travel;
    logic [7:0]         infrared_code;
  } frame_t;

endpackage

### hdl/spd_byte_if.sv
interface spd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### hdl/spd_result_if.sv
interface spd_result_if;
  logic               valid;
  logic               ready;
  logic [15:0]        left_raw;
  logic [15:0]        front_left_raw;
  logic [15:0]        front_right_raw;
  logic [15:0]        right_raw;
  logic               left_flag;
  logic               front_left_flag;
  logic               front_right_flag;
  logic               right_flag;
  logic signed [15:0] travel;
  logic [7:0]         infrared_code;

  modport source (
    output valid, output left_raw, output front_left_raw, output front_right_raw,
    output right_raw, output left_flag, output front_left_flag,
    output front_right_flag, output right_flag, output travel, output infrared_code,
    input ready
  );
  modport sink (
    input valid, input left_raw, input front_left_raw, input front_right_raw,
    input right_raw, input left_flag, input front_left_flag,
    input front_right_flag, input right_flag, input travel, input infrared_code,
    output ready
  );
endinterface

### hdl/spd_cfg_if.sv
interface spd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [spd_pkg::CFG_INDEX_W-1:0]  index;
  logic [spd_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/spd_cfg_regs.sv
module spd_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  spd_cfg_if.sink        cfg,
  output spd_pkg::cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.threshold_left        <= '0;
      regs.threshold_front_left  <= '0;
      regs.threshold_front_right <= '0;
      regs.threshold_right       <= '0;
      regs.flag_polarity         <= 1'b1;
    end else if (cfg.valid) begin
      case (cfg.index)
        spd_pkg::CFG_THR_LEFT:        regs.threshold_left        <= cfg.data;
        spd_pkg::CFG_THR_FRONT_LEFT:  regs.threshold_front_left  <= cfg.data;
        spd_pkg::CFG_THR_FRONT_RIGHT: regs.threshold_front_right <= cfg.data;
        spd_pkg::CFG_THR_RIGHT:       regs.threshold_right       <= cfg.data;
        spd_pkg::CFG_POLARITY:        regs.flag_polarity         <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

### hdl/spd_frame_align.sv
`include "assert_macros.svh"

module spd_frame_align (
  input  logic            clk,
  input  logic            rst,
  spd_byte_if.sink        stream,
  input  logic            hold,
  output logic            hit,
  output spd_pkg::frame_t frame
);

  logic                        s1_valid;
  logic [7:0]                  s1_byte;
  logic [7:0]                  win [spd_pkg::HOLD_LEN];
  logic [spd_pkg::FILL_W-1:0]  fill;
  logic [7:0]                  wsum;

  logic       advance;
  logic       full;
  logic       ids_ok;
  logic       frame_ok;
  logic [7:0] total;

  assign frame_ok     = s1_valid && full && ids_ok && (total == 8'd0);
  assign advance      = s1_valid && !(frame_ok && hold);
  assign stream.ready = !s1_valid || advance;
  assign full         = (fill == spd_pkg::FILL_W'(spd_pkg::HOLD_LEN));
  assign total        = wsum + s1_byte;

  assign ids_ok = (win[0]  == spd_pkg::HDR_LEN_BYTE)  && (win[1]  == spd_pkg::HDR_SYNC_BYTE) &&
                  (win[2]  == spd_pkg::ID_LEFT)       && (win[5]  == spd_pkg::ID_FRONT_LEFT) &&
                  (win[8]  == spd_pkg::ID_FRONT_RGT)  && (win[11] == spd_pkg::ID_RIGHT) &&
                  (win[14] == spd_pkg::ID_TRAVEL)     && (win[17] == spd_pkg::ID_INFRARED);

  assign hit = advance && frame_ok;

  assign frame.left_raw        = {win[3], win[4]};
  assign frame.front_left_raw  = {win[6], win[7]};
  assign frame.front_right_raw = {win[9], win[10]};
  assign frame.right_raw       = {win[12], win[13]};
  assign frame.travel          = {win[15], win[16]};
  assign frame.infrared_code   = win[18];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (stream.ready) begin
      s1_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.ready && stream.valid) begin
      s1_byte <= stream.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      wsum <= '0;
    end else if (advance) begin
      if (!full) begin
        fill <= fill + 1'b1;
        wsum <= total;
      end else if (hit) begin
        fill <= '0;
        wsum <= '0;
      end else begin
        wsum <= total - win[0];
      end
    end
  end

  // A rejected frame slides down by one byte and keeps the newest byte at the top.
  always_ff @(posedge clk) begin
    if (advance) begin
      if (!full) begin
        win[fill] <= s1_byte;
      end else if (!hit) begin
        for (int k = 0; k < spd_pkg::HOLD_LEN - 1; k++) begin
          win[k] <= win[k+1];
        end
        win[spd_pkg::HOLD_LEN-1] <= s1_byte;
      end
    end
  end

  `SPD_ASSERT(a_fill_range, fill <= spd_pkg::FILL_W'(spd_pkg::HOLD_LEN))
  `SPD_ASSERT_NEXT(a_hit_empties, hit, fill == '0)
  `SPD_ASSERT_NEXT(a_fill_step, advance && !full, fill == $past(fill) + 1'b1)

endmodule

### hdl/spd_out_stage.sv
`include "assert_macros.svh"

module spd_out_stage (
  input  logic            clk,
  input  logic            rst,
  input  spd_pkg::cfg_t   regs,
  input  logic            hit,
  input  spd_pkg::frame_t frame,
  output logic            hold,
  spd_result_if.source    result
);

  logic valid;

  assign hold         = valid && !result.ready;
  assign result.valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (hit) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      result.left_raw         <= frame.left_raw;
      result.front_left_raw   <= frame.front_left_raw;
      result.front_right_raw  <= frame.front_right_raw;
      result.right_raw        <= frame.right_raw;
      result.travel           <= frame.travel;
      result.infrared_code    <= frame.infrared_code;
      result.left_flag        <= (frame.left_raw > regs.threshold_left) ~^
                                 regs.flag_polarity;
      result.front_left_flag  <= (frame.front_left_raw > regs.threshold_front_left) ~^
                                 regs.flag_polarity;
      result.front_right_flag <= (frame.front_right_raw > regs.threshold_front_right) ~^
                                 regs.flag_polarity;
      result.right_flag       <= (frame.right_raw > regs.threshold_right) ~^
                                 regs.flag_polarity;
    end
  end

  `SPD_ASSERT(a_no_overwrite, hit |-> !hold)

endmodule

### hdl/sensor_packet_deframer_core.sv
// Sensor frame deframer: takes one stream byte per cycle and emits one result
// transaction per valid 20-byte frame (fixed header and id bytes, byte sum zero
// modulo 256); a failing frame slides by one byte to regain alignment. A byte
// is captured in an input register, checked against the 19 held bytes in the
// next cycle, and a passing frame is loaded into the result register at the
// end of that cycle unless the stream stalls. Sustained rate is one byte per
// cycle while the stream does not stall. The stream stalls only when the byte
// in the input register completes another valid frame while the previous
// result still waits for the sink.
module sensor_packet_deframer_core (
  input  logic          clk,
  input  logic          rst,
  spd_byte_if.sink      stream,
  spd_cfg_if.sink       cfg,
  spd_result_if.source  result
);

  spd_pkg::cfg_t   regs;
  spd_pkg::frame_t frame;
  logic            hit;
  logic            hold;

  spd_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  spd_frame_align u_frame_align (
    .clk    (clk),
    .rst    (rst),
    .stream (stream),
    .hold   (hold),
    .hit    (hit),
    .frame  (frame)
  );

  spd_out_stage u_out_stage (
    .clk    (clk),
    .rst    (rst),
    .regs   (regs),
    .hit    (hit),
    .frame  (frame),
    .hold   (hold),
    .result (result)
  );

endmodule
